>>> hdl/lvr_pkg.sv
`default_nettype none
package lvr_pkg;

    // Field widths of the stream payloads
    localparam int COORD_W = 16;
    localparam int TILE_W  = 8;
    // The major span field holds at most 127
    localparam int MAG_W   = 7;
    // A minor delta never exceeds the major span in magnitude
    localparam int DLT_W   = MAG_W + 1;
    // Rounding accumulator, remainder plus twice a delta: -2*mag .. 4*mag-1
    localparam int ACC_W   = MAG_W + 3;

    localparam int IN_DATA_W  = 6 * COORD_W + TILE_W;
    localparam int OUT_DATA_W = 3 * COORD_W + TILE_W;

    typedef struct packed {
        logic                    span_err;
        logic [TILE_W-1:0]       tile;
        logic [MAG_W-1:0]        mag;
        logic signed [DLT_W-1:0] dz;
        logic signed [DLT_W-1:0] dy;
        logic signed [DLT_W-1:0] dx;
        logic [COORD_W-1:0]      sz;
        logic [COORD_W-1:0]      sy;
        logic [COORD_W-1:0]      sx;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage
`default_nettype wire

>>> hdl/lvr_front.sv
`default_nettype none
module lvr_front #(
    parameter int MAX_SPAN = 63
) (
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [lvr_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output lvr_pkg::t_cmd                      o_q_cmd
);
    import lvr_pkg::*;

    logic [COORD_W-1:0] w_s [3];
    logic [COORD_W-1:0] w_e [3];
    logic [COORD_W:0]   w_d [3];
    logic [COORD_W:0]   w_a [3];
    logic [1:0]         w_big;
    logic [COORD_W:0]   w_mag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s[i] = i_s_axis_tdata[i*COORD_W +: COORD_W];
            w_e[i] = i_s_axis_tdata[(i+3)*COORD_W +: COORD_W];
            w_d[i] = {w_e[i][COORD_W-1], w_e[i]} - {w_s[i][COORD_W-1], w_s[i]};
            w_a[i] = w_d[i][COORD_W] ? (~w_d[i] + 1'b1) : w_d[i];
        end
        // earliest axis wins ties
        w_big = 2'd0;
        w_mag = w_a[0];
        if (w_a[1] > w_mag) begin
            w_big = 2'd1;
            w_mag = w_a[1];
        end
        if (w_a[2] > w_mag) begin
            w_big = 2'd2;
            w_mag = w_a[2];
        end
    end

    always_comb begin
        o_q_cmd          = '0;
        o_q_cmd.sx       = w_s[0];
        o_q_cmd.sy       = w_s[1];
        o_q_cmd.sz       = w_s[2];
        o_q_cmd.dx       = w_d[0][DLT_W-1:0];
        o_q_cmd.dy       = w_d[1][DLT_W-1:0];
        o_q_cmd.dz       = w_d[2][DLT_W-1:0];
        o_q_cmd.mag      = w_mag[MAG_W-1:0];
        o_q_cmd.tile     = i_s_axis_tdata[6*COORD_W +: TILE_W];
        o_q_cmd.span_err = (w_mag > (COORD_W+1)'(MAX_SPAN));
    end

    // zero-length lines are consumed here and never reach the queue
    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full && (w_mag != '0) && (w_big != 2'd3);

endmodule
`default_nettype wire

>>> hdl/lvr_fifo.sv
`default_nettype none
module lvr_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lvr_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output lvr_pkg::t_cmd      o_data,
    output logic               o_empty
);
    import lvr_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

>>> hdl/lvr_back.sv
`default_nettype none
module lvr_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_empty,
    input  wire lvr_pkg::t_cmd                  i_q_cmd,
    output logic                                o_q_pop,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [lvr_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);
    import lvr_pkg::*;

    t_state                   r_state, n_state;
    logic [COORD_W-1:0]       r_c [3];
    logic [COORD_W-1:0]       n_c [3];
    logic signed [ACC_W-1:0]  r_r [3];
    logic signed [ACC_W-1:0]  n_r [3];
    logic signed [DLT_W-1:0]  r_d [3];
    logic signed [DLT_W-1:0]  n_d [3];
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic [MAG_W-1:0]         r_t, n_t;
    logic [TILE_W-1:0]        r_tile, n_tile;
    logic                     r_err, n_err;

    logic                     r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data, n_out_data;
    logic                     r_out_err, n_out_err;
    logic                     r_out_last, n_out_last;

    logic                     w_slot;
    logic                     w_last;
    logic signed [ACC_W-1:0]  w_two_mag;
    logic signed [ACC_W-1:0]  w_sum [3];

    assign w_slot    = !r_out_valid || i_m_axis_tready;
    assign w_last    = (r_t == r_mag);
    assign w_two_mag = $signed({2'b00, r_mag, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c        <= n_c;
        r_r        <= n_r;
        r_d        <= n_d;
        r_mag      <= n_mag;
        r_t        <= n_t;
        r_tile     <= n_tile;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    // Each axis carries floor((2*t*d + mag) / (2*mag)) as a running coordinate
    // and remainder; the major axis falls out as a plain +-1 step.
    always_comb begin
        n_state     = r_state;
        n_c         = r_c;
        n_r         = r_r;
        n_d         = r_d;
        n_mag       = r_mag;
        n_t         = r_t;
        n_tile      = r_tile;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        for (int i = 0; i < 3; i++) begin
            w_sum[i] = r_r[i] + {{(ACC_W-DLT_W-1){r_d[i][DLT_W-1]}}, r_d[i], 1'b0};
        end

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_c[0]  = i_q_cmd.sx;
                    n_c[1]  = i_q_cmd.sy;
                    n_c[2]  = i_q_cmd.sz;
                    n_d[0]  = i_q_cmd.dx;
                    n_d[1]  = i_q_cmd.dy;
                    n_d[2]  = i_q_cmd.dz;
                    for (int i = 0; i < 3; i++) begin
                        n_r[i] = $signed({3'b000, i_q_cmd.mag});
                    end
                    n_mag   = i_q_cmd.mag;
                    n_t     = '0;
                    n_tile  = i_q_cmd.tile;
                    n_err   = i_q_cmd.span_err;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    if (r_err) begin
                        n_out_data = '0;
                        n_out_err  = 1'b1;
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_out_data = {r_tile, r_c[2], r_c[1], r_c[0]};
                        n_out_err  = 1'b0;
                        n_out_last = w_last;
                        for (int i = 0; i < 3; i++) begin
                            if (w_sum[i] >= w_two_mag) begin
                                n_r[i] = w_sum[i] - w_two_mag;
                                n_c[i] = r_c[i] + 1'b1;
                            end else if (w_sum[i] < 0) begin
                                n_r[i] = w_sum[i] + w_two_mag;
                                n_c[i] = r_c[i] - 1'b1;
                            end else begin
                                n_r[i] = w_sum[i];
                            end
                        end
                        n_t = r_t + 1'b1;
                        if (w_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

>>> hdl/line_voxel_rasterizer_3d.sv
`default_nettype none
// 3D line voxelizer. Each input transfer carries a start point, an end point
// and a tile value; the block streams out every voxel of the line from start
// to end, one voxel per output transfer, with tlast on the final voxel. The
// major axis is the first axis with the largest absolute delta; minor axes
// round half up exactly. A zero-length line produces nothing. A line whose
// major span exceeds MAX_SPAN produces a single transfer with tuser set and
// zero data. Timing: the front classifies a line in the cycle it is taken and
// drops it into a two-entry queue; the stepping unit loads a line from the
// queue in its idle state and then emits one voxel per cycle while the output
// is not stalled. Input is accepted whenever the queue has room.
module line_voxel_rasterizer_3d #(
    parameter int MAX_SPAN = 63
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, tile_value
    input  wire logic [103:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // voxel_x, voxel_y, voxel_z, voxel_tile
    output logic [55:0]       o_m_axis_tdata,
    // span_error
    output logic              o_m_axis_tuser,
    output logic              o_m_axis_tlast
);
    import lvr_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    lvr_front #(
        .MAX_SPAN(MAX_SPAN)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (w_full),
        .o_q_push        (w_push),
        .o_q_cmd         (w_push_cmd)
    );

    lvr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_cmd),
        .o_empty (w_empty)
    );

    lvr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_empty),
        .i_q_cmd         (w_head_cmd),
        .o_q_pop         (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> verif/voxel_stream_checker.sv
`timescale 1ns / 1ps
module voxel_stream_checker
    import lvr_pkg::*;
#(
    parameter int MAX_SPAN = 63
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_valid,
    input  wire logic                  i_s_ready,
    // start_x, start_y, start_z, end_x, end_y, end_z, tile_value
    input  wire logic [IN_DATA_W-1:0]  i_s_data,
    input  wire logic                  i_m_valid,
    input  wire logic                  i_m_ready,
    // voxel_x, voxel_y, voxel_z, voxel_tile
    input  wire logic [OUT_DATA_W-1:0] i_m_data,
    // span_error
    input  wire logic                  i_m_user,
    input  wire logic                  i_m_last,
    output int                         o_pending,
    output int                         o_errors
);

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [TILE_W-1:0]         tile;
        logic                      span_err;
        logic                      last;
    } voxel_t;

    voxel_t voxel_q[$];
    int     pending_count = 0;
    int     fail_count = 0;

    assign o_pending = pending_count;
    assign o_errors  = fail_count;

    function automatic int mag_of(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Queue every voxel that one accepted line should produce.
    function automatic void rasterize_line(logic [IN_DATA_W-1:0] data);
        int     s[3];
        int     d[3];
        int     c[3];
        int     major;
        int     span;
        int     dir;
        int     num;
        int     den;
        int     q;
        voxel_t v;
        for (int i = 0; i < 3; i++) begin
            s[i] = $signed(data[i*COORD_W +: COORD_W]);
            d[i] = int'($signed(data[(i+3)*COORD_W +: COORD_W])) - s[i];
        end
        major = 0;
        for (int i = 1; i < 3; i++)
            if (mag_of(d[i]) > mag_of(d[major]))
                major = i;
        span = mag_of(d[major]);
        if (span == 0)
            return;
        if (span > MAX_SPAN) begin
            v.x = '0;
            v.y = '0;
            v.z = '0;
            v.tile = '0;
            v.span_err = 1'b1;
            v.last = 1'b1;
            voxel_q.push_back(v);
            return;
        end
        dir = (d[major] > 0) ? 1 : -1;
        for (int t = 0; t <= span; t++) begin
            for (int i = 0; i < 3; i++) begin
                if (i == major) begin
                    c[i] = s[i] + dir * t;
                end else begin
                    // round half up: floor((2*t*d + span) / (2*span))
                    num = 2 * t * d[i] + span;
                    den = 2 * span;
                    q = num / den;
                    if (num < 0 && (num % den) != 0)
                        q = q - 1;
                    c[i] = s[i] + q;
                end
            end
            v.x = COORD_W'(c[0]);
            v.y = COORD_W'(c[1]);
            v.z = COORD_W'(c[2]);
            v.tile = data[6*COORD_W +: TILE_W];
            v.span_err = 1'b0;
            v.last = (t == span);
            voxel_q.push_back(v);
        end
    endfunction

    function automatic void check_field(string name, int want, int seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        voxel_t want;
        if (i_rst_n) begin
            if (i_s_valid && i_s_ready)
                rasterize_line(i_s_data);
            if (i_m_valid && i_m_ready) begin
                if (voxel_q.size() == 0) begin
                    $error("voxel transfer with no line pending: data %h user %b last %b",
                           i_m_data, i_m_user, i_m_last);
                    fail_count++;
                end else begin
                    want = voxel_q.pop_front();
                    check_field("voxel_x", want.x, $signed(i_m_data[0 +: COORD_W]));
                    check_field("voxel_y", want.y, $signed(i_m_data[COORD_W +: COORD_W]));
                    check_field("voxel_z", want.z, $signed(i_m_data[2*COORD_W +: COORD_W]));
                    check_field("voxel_tile", want.tile, i_m_data[3*COORD_W +: TILE_W]);
                    check_field("span_error", want.span_err, i_m_user);
                    check_field("last", want.last, i_m_last);
                end
            end
        end
        pending_count = voxel_q.size();
    end

endmodule

>>> verif/tb_line_voxel_rasterizer_3d.sv
`timescale 1ns / 1ps
module tb_line_voxel_rasterizer_3d;
    import lvr_pkg::*;

    localparam int LINE_MAX_SPAN  = 63;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * LINE_MAX_SPAN + 20;
    localparam int ITEMS_PER_PHASE = 65;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_user;
    logic                  m_last;
    int                    pending;
    int                    errors;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    quiet_cycles = 0;

    line_voxel_rasterizer_3d #(
        .MAX_SPAN(LINE_MAX_SPAN)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    voxel_stream_checker #(
        .MAX_SPAN(LINE_MAX_SPAN)
    ) checker_i (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_s_valid(s_valid),
        .i_s_ready(s_ready),
        .i_s_data (s_data),
        .i_m_valid(m_valid),
        .i_m_ready(m_ready),
        .i_m_data (m_data),
        .i_m_user (m_user),
        .i_m_last (m_last),
        .o_pending(pending),
        .o_errors (errors)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_line(int sx, int sy, int sz,
                                                       int ex, int ey, int ez,
                                                       int tile);
        return {TILE_W'(tile), COORD_W'(ez), COORD_W'(ey), COORD_W'(ex),
                COORD_W'(sz), COORD_W'(sy), COORD_W'(sx)};
    endfunction

    // Mostly well-formed short lines, plus empty, oversized and wild ones.
    function automatic logic [IN_DATA_W-1:0] random_line();
        logic signed [COORD_W-1:0] r16;
        int s[3];
        int e[3];
        int kind;
        int span;
        int major;
        int off;
        kind = $urandom_range(99);
        major = $urandom_range(2);
        if (kind < 12)
            span = $urandom_range(LINE_MAX_SPAN + 1, 3 * LINE_MAX_SPAN);
        else if ($urandom_range(3) == 0)
            span = $urandom_range(1, LINE_MAX_SPAN);
        else
            span = $urandom_range(1, 16);
        for (int i = 0; i < 3; i++) begin
            r16 = COORD_W'($urandom);
            if ($urandom_range(9) == 0)
                r16 = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            s[i] = r16;
            if (i == major)
                off = $urandom_range(1) ? span : -span;
            else
                off = $urandom_range(2 * span) - span;
            e[i] = s[i] + off;
            if (e[i] > 32767 || e[i] < -32768)
                e[i] = s[i] - off;
            if (kind >= 12 && kind < 22) begin
                e[i] = s[i];
            end else if (kind >= 22 && kind < 27) begin
                r16 = COORD_W'($urandom);
                e[i] = r16;
            end
        end
        return pack_line(s[0], s[1], s[2], e[0], e[1], e[2], $urandom_range(255));
    endfunction

    task automatic send_line(input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data <= data;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero length lines at both corners of the space
        send_line(pack_line(-32768, -32768, -32768, -32768, -32768, -32768, 8'h5a));
        send_line(pack_line(32767, 32767, 32767, 32767, 32767, 32767, 8'ha5));
        // single step, x and negative z
        send_line(pack_line(0, 0, 0, 1, 0, 0, 0));
        send_line(pack_line(10, -10, 5, 10, -10, 4, 255));
        // longest legal span from the low edge, x major
        send_line(pack_line(-32768, 0, 0, -32705, 17, -40, 8'haa));
        // x and y tie at the top edge; x wins
        send_line(pack_line(32767, 32767, 32767, 32704, 32704, 32740, 8'h55));
        // y and z tie; y wins
        send_line(pack_line(0, 0, 0, 3, 10, 10, 8'h0f));
        send_line(pack_line(0, 0, 0, 0, -5, 5, 8'hf0));
        // z major
        send_line(pack_line(0, 0, 0, 1, 2, 7, 8'h81));
        send_line(pack_line(100, -200, 300, 97, -196, 250, 8'h7e));
        // half-way rounding, positive and negative minor
        send_line(pack_line(0, 0, 0, 2, 1, 0, 8'h01));
        send_line(pack_line(0, 0, 0, 2, -1, 0, 8'h80));
        send_line(pack_line(-7, 3, 0, -3, 1, 2, 8'h3c));
        // span over the limit on each axis, just over on x and y
        send_line(pack_line(0, 0, 0, 64, 0, 0, 8'hff));
        send_line(pack_line(0, 0, 0, 0, -64, 0, 8'h11));
        send_line(pack_line(100, 100, 100, 100, 100, -100, 8'h22));
        // full range diagonal, rejected
        send_line(pack_line(-32768, -32768, -32768, 32767, 32767, 32767, 8'hc3));
        send_line(pack_line(32767, -32768, 0, -32768, 32767, 0, 8'h3c));
        // legal line straight after a rejected one
        send_line(pack_line(32767, -32768, 0, 32705, -32706, 63, 8'h99));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 56;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 56;
                end
                default: begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_line(random_line());
        end

        s_valid <= 1'b0;
        stall_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
